FILE: sv/pmci_pkg.sv
// Shared constants, knot tables and types for the periodic monotone cubic interpolator.
package pmci_pkg;

	localparam int ANGLE_W = 24;
	localparam int SEL_W   = 2;
	localparam int VALUE_W = 32;
	localparam int KNOTS   = 16;
	localparam int KNOT_W  = $clog2(KNOTS);
	localparam int TQ      = 20;

	// one turn and one segment in angle units
	localparam int FULL     = 360 * 256;
	localparam int SEG      = FULL / KNOTS;
	localparam int FULL_W   = 17;
	localparam int SEG_W    = 13;
	localparam int RED_W    = 25;

	// bias that makes any angle nonnegative and is a whole number of turns
	localparam logic [RED_W-1:0] ANGLE_BIAS = 25'd8478720;

	// floor(2^40 / FULL)
	localparam logic [23:0] RECIP_FULL  = 24'd11930464;
	localparam int          RECIP_FULL_SH = 40;

	// t = floor(w * 2^13 / 45); floor(2^32 / 45)
	localparam int          T_DIV       = 45;
	localparam logic [26:0] RECIP_TDIV  = 27'd95443717;
	localparam int          RECIP_TDIV_SH = 19;

	// final scale: 200 << 12 = 2^15 * 25
	localparam int          ROUND_HALF  = 409600;
	localparam int          OUT_DIV     = 25;
	localparam logic [33:0] RECIP_OUT   = 34'd10995116277;
	localparam int          RECIP_OUT_SH = 38;

	localparam logic [11:0] KNOT_Y [4][KNOTS] = '{
		'{12'd2100, 12'd2100, 12'd2100, 12'd1700, 12'd1600, 12'd1440, 12'd1160, 12'd1560,
		  12'd1600, 12'd1840, 12'd1800, 12'd1700, 12'd2020, 12'd2320, 12'd2400, 12'd2000},
		'{12'd400, 12'd330, 12'd340, 12'd330, 12'd410, 12'd350, 12'd340, 12'd380,
		  12'd360, 12'd430, 12'd480, 12'd480, 12'd430, 12'd560, 12'd550, 12'd520},
		'{12'd10, 12'd10, 12'd10, 12'd7, 12'd13, 12'd8, 12'd4, 12'd5,
		  12'd7, 12'd17, 12'd20, 12'd18, 12'd17, 12'd15, 12'd13, 12'd13},
		'{default: 12'd0}
	};

	// harmonic-mean slope term at each knot, units 2^-16/200
	localparam logic signed [27:0] KNOT_S [4][KNOTS] = '{
		'{28'sd0, 28'sd0, 28'sd0, -28'sd10485760, -28'sd8065969, -28'sd13345513, 28'sd0,
		  28'sd4766255, 28'sd4493897, 28'sd0, -28'sd3744914, 28'sd0, 28'sd20295019,
		  28'sd8278232, 28'sd0, 28'sd0},
		'{-28'sd5794762, 28'sd0, 28'sd0, 28'sd0, 28'sd0, -28'sd1123474, 28'sd0, 28'sd0,
		  28'sd0, 28'sd3822933, 28'sd0, 28'sd0, 28'sd0, 28'sd0, -28'sd983040,
		  -28'sd3145728},
		'{28'sd0, 28'sd0, 28'sd0, 28'sd0, 28'sd0, -28'sd291271, 28'sd0, 28'sd87381,
		  28'sd218453, 28'sd302474, 28'sd0, -28'sd87381, -28'sd87381, -28'sd131072,
		  28'sd0, 28'sd0},
		'{default: 28'sd0}
	};

	typedef struct packed {
		logic              valid;
		logic [SEL_W-1:0]  sel;
		logic [KNOT_W-1:0] left;
		logic [TQ-1:0]     t;
	} phase_t;

endpackage

FILE: sv/pmci_phase.sv
// Angle reduction, segment search and Q20 fraction pipeline.
module pmci_phase import pmci_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  logic [ANGLE_W-1:0] angle,
	input  logic [SEL_W-1:0]   table_select,
	output phase_t             ph
);

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic [SEL_W-1:0] sel_s1, sel_s2, sel_s3, sel_s4, sel_s5, sel_s6, sel_s7;
	logic [RED_W-1:0] a_s1, a_s2;
	logic [7:0] qe_s2;
	logic [FULL_W:0] rem_s3;
	logic [FULL_W-1:0] r_s4;
	logic [KNOT_W-1:0] left_s5, left_s6, left_s7;
	logic [SEG_W-1:0] w_s5, w_s6;
	logic [TQ-1:0] tq_s6, t_s7;

	logic [RED_W-1:0] a_in;
	logic [48:0] prod_full;
	logic [RED_W-1:0] rem_full;
	logic [KNOT_W-1:0] left_c;
	logic [FULL_W-1:0] w_full;
	logic [39:0] prod_t;
	logic [25:0] x_t, rem_t;

	assign a_in      = {angle[ANGLE_W-1], angle} + ANGLE_BIAS;
	assign prod_full = 49'(a_s1) * 49'(RECIP_FULL);
	assign rem_full  = a_s2 - RED_W'(qe_s2) * RED_W'(FULL);
	assign prod_t    = 40'(w_s5) * 40'(RECIP_TDIV);
	assign x_t       = {w_s6, 13'b0};
	assign rem_t     = x_t - 26'(tq_s6) * 26'(T_DIV);
	assign w_full    = r_s4 - FULL_W'(left_c) * FULL_W'(SEG);
	assign ph        = '{valid: v_s7, sel: sel_s7, left: left_s7, t: t_s7};

	always_comb begin
		left_c = '0;
		for (int k = 1; k < KNOTS; k++) begin
			if (r_s4 >= FULL_W'(k * SEG)) begin
				left_c = KNOT_W'(k);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1   <= a_in;
			sel_s1 <= table_select;
			qe_s2  <= prod_full[RECIP_FULL_SH+7:RECIP_FULL_SH];
			a_s2   <= a_s1;
			sel_s2 <= sel_s1;
			rem_s3 <= rem_full[FULL_W:0];
			sel_s3 <= sel_s2;
			r_s4   <= (rem_s3 >= (FULL_W+1)'(FULL)) ?
				FULL_W'(rem_s3 - (FULL_W+1)'(FULL)) : rem_s3[FULL_W-1:0];
			sel_s4 <= sel_s3;
			left_s5 <= left_c;
			w_s5    <= w_full[SEG_W-1:0];
			sel_s5  <= sel_s4;
			tq_s6   <= prod_t[RECIP_TDIV_SH+TQ-1:RECIP_TDIV_SH];
			w_s6    <= w_s5;
			left_s6 <= left_s5;
			sel_s6  <= sel_s5;
			t_s7    <= (rem_t >= 26'(T_DIV)) ? tq_s6 + 1'b1 : tq_s6;
			left_s7 <= left_s6;
			sel_s7  <= sel_s6;
		end
	end

endmodule

FILE: sv/pmci_hermite.sv
// Knot lookup, Hermite basis, weighted sum and final rounding pipeline.
module pmci_hermite import pmci_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  phase_t             ph,
	output logic               out_valid,
	output logic [VALUE_W-1:0] value
);

	logic v_h1, v_h2, v_h3, v_h4, v_h5, v_h6, v_h7, v_h8, v_h9;
	logic [TQ-1:0] t_h1, t_h2, t_h3, t2_h2, t2_h3, t3_h3;
	logic [11:0] y0_h1, y0_h2, y0_h3, y0_h4, y0_h5;
	logic signed [12:0] d_h1, d_h2, d_h3, d_h4;
	logic signed [27:0] s0_h1, s0_h2, s0_h3, s0_h4, s1_h1, s1_h2, s1_h3, s1_h4;
	logic signed [22:0] h01_h4, h10_h4, h11_h4;
	logic signed [35:0] p1_h5;
	logic signed [50:0] p2_h5, p3_h5;
	logic signed [51:0] acc_h6;
	logic [32:0] x_h7, x_h8, x_h9;
	logic [50:0] ph_h8;
	logic [49:0] pl_h8;
	logic [28:0] qe_h9;

	logic [KNOT_W-1:0] right_c;
	logic [39:0] tt_c, t2t_c;
	logic signed [22:0] t_e, t2_e, t3_e;
	logic signed [51:0] rnd_c;
	logic [66:0] qsum_c;
	logic [33:0] rem_c;

	assign right_c = ph.left + 1'b1;
	assign tt_c    = 40'(t_h1) * 40'(t_h1);
	assign t2t_c   = 40'(t2_h2) * 40'(t_h2);
	assign t_e     = $signed({3'b0, t_h3});
	assign t2_e    = $signed({3'b0, t2_h3});
	assign t3_e    = $signed({3'b0, t3_h3});
	assign rnd_c   = acc_h6 + 52'(ROUND_HALF);
	assign qsum_c  = {ph_h8, 16'b0} + 67'(pl_h8);
	assign rem_c   = {1'b0, x_h9} - 34'(qe_h9) * 34'(OUT_DIV);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_h1 <= 1'b0;
			v_h2 <= 1'b0;
			v_h3 <= 1'b0;
			v_h4 <= 1'b0;
			v_h5 <= 1'b0;
			v_h6 <= 1'b0;
			v_h7 <= 1'b0;
			v_h8 <= 1'b0;
			v_h9 <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			v_h1 <= ph.valid;
			v_h2 <= v_h1;
			v_h3 <= v_h2;
			v_h4 <= v_h3;
			v_h5 <= v_h4;
			v_h6 <= v_h5;
			v_h7 <= v_h6;
			v_h8 <= v_h7;
			v_h9 <= v_h8;
			out_valid <= v_h9;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t_h1  <= ph.t;
			y0_h1 <= KNOT_Y[ph.sel][ph.left];
			d_h1  <= $signed({1'b0, KNOT_Y[ph.sel][right_c]})
				- $signed({1'b0, KNOT_Y[ph.sel][ph.left]});
			s0_h1 <= KNOT_S[ph.sel][ph.left];
			s1_h1 <= KNOT_S[ph.sel][right_c];

			t2_h2 <= tt_c[TQ+TQ-1:TQ];
			t_h2  <= t_h1;
			y0_h2 <= y0_h1;
			d_h2  <= d_h1;
			s0_h2 <= s0_h1;
			s1_h2 <= s1_h1;

			t3_h3 <= t2t_c[TQ+TQ-1:TQ];
			t2_h3 <= t2_h2;
			t_h3  <= t_h2;
			y0_h3 <= y0_h2;
			d_h3  <= d_h2;
			s0_h3 <= s0_h2;
			s1_h3 <= s1_h2;

			h01_h4 <= 23'sd3 * t2_e - 23'sd2 * t3_e;
			h10_h4 <= t3_e - 23'sd2 * t2_e + t_e;
			h11_h4 <= t3_e - t2_e;
			y0_h4  <= y0_h3;
			d_h4   <= d_h3;
			s0_h4  <= s0_h3;
			s1_h4  <= s1_h3;

			p1_h5 <= 36'(h01_h4) * 36'(d_h4);
			p2_h5 <= 51'(h10_h4) * 51'(s0_h4);
			p3_h5 <= 51'(h11_h4) * 51'(s1_h4);
			y0_h5 <= y0_h4;

			acc_h6 <= $signed({4'b0, y0_h5, 36'b0}) + (52'(p1_h5) <<< 16)
				+ 52'(p2_h5) + 52'(p3_h5);

			x_h7 <= (!acc_h6[51] && acc_h6 != '0) ? rnd_c[47:15] : '0;

			ph_h8 <= 51'(x_h7[32:16]) * 51'(RECIP_OUT);
			pl_h8 <= 50'(x_h7[15:0]) * 50'(RECIP_OUT);
			x_h8  <= x_h7;

			qe_h9 <= qsum_c[RECIP_OUT_SH+28:RECIP_OUT_SH];
			x_h9  <= x_h8;

			value <= VALUE_W'((rem_c >= 34'(OUT_DIV)) ? qe_h9 + 1'b1 : qe_h9);
		end
	end

endmodule

FILE: sv/periodic_monotone_cubic_interp_unit.sv
// Top level of the periodic monotone cubic interpolator.
//
//  channel | signals                           | transfer when
//  in      | in_valid, in_ready, angle, table_select | in_valid & in_ready
//  out     | out_valid, out_ready, value       | out_valid & out_ready
//
// One item per cycle while no result is held; an input transfer reaches the result through
// 7 stages of angle reduction and fraction, then 10 of lookup, Hermite sum, rounding.
// All stages advance together; a held result freezes the whole pipeline.
// Reset clears the valid bits only; no clearing pass.
module periodic_monotone_cubic_interp_unit import pmci_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [ANGLE_W-1:0] angle,
	input  logic [SEL_W-1:0]   table_select,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [VALUE_W-1:0] value
);

	logic   en;
	phase_t ph;

	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	pmci_phase u_phase (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (en),
		.in_valid     (in_valid),
		.angle        (angle),
		.table_select (table_select),
		.ph           (ph)
	);

	pmci_hermite u_hermite (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.ph        (ph),
		.out_valid (out_valid),
		.value     (value)
	);

`ifndef SYNTH
	a_stall_holds_phase: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(ph))
		else $error("phase stage moved during stall");
	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |-> !in_ready)
		else $error("input taken while result held");
	a_value_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> value[31:29] == 3'b000)
		else $error("result exceeds table range");
`endif

endmodule

FILE: sim/tb.sv
// Self-checking testbench for the periodic monotone cubic interpolator.
module tb import pmci_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int N_RANDOM   = 1500;
	localparam int STALL_LIMIT = 2000;
	localparam logic [SEL_W-1:0] SEL_SCALE  = 2'd0;
	localparam logic [SEL_W-1:0] SEL_SHAPE  = 2'd1;
	localparam logic [SEL_W-1:0] SEL_FREQ   = 2'd2;
	localparam logic [SEL_W-1:0] SEL_UNUSED = 2'd3;

	typedef struct packed {
		logic [ANGLE_W-1:0] ang;
		logic [SEL_W-1:0]   sel;
	} query_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [ANGLE_W-1:0] angle = '0;
	logic [SEL_W-1:0]   table_select = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [VALUE_W-1:0] value;

	query_t            pending_q[$];
	logic [VALUE_W-1:0] expected_values[$];
	int  errors = 0;
	int  sent = 0;
	int  received = 0;
	int  idle_cycles = 0;
	int  send_wait = 0;
	int  recv_wait = 0;
	bit  in_fire = 0;
	bit  out_fire = 0;
	int  sel_count[4];

	periodic_monotone_cubic_interp_unit u_dut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.angle(angle), .table_select(table_select), .out_valid(out_valid),
		.out_ready(out_ready), .value(value)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic longint knot_at(logic [SEL_W-1:0] sel, longint k);
		int kk;
		int scale_tab[16] = '{2100, 2100, 2100, 1700, 1600, 1440, 1160, 1560,
			1600, 1840, 1800, 1700, 2020, 2320, 2400, 2000};
		int shape_tab[16] = '{400, 330, 340, 330, 410, 350, 340, 380,
			360, 430, 480, 480, 430, 560, 550, 520};
		int freq_tab[16] = '{10, 10, 10, 7, 13, 8, 4, 5,
			7, 17, 20, 18, 17, 15, 13, 13};
		kk = int'(k % KNOTS);
		case (sel)
			SEL_SCALE: return longint'(scale_tab[kk]);
			SEL_SHAPE: return longint'(shape_tab[kk]);
			default: return longint'(freq_tab[kk]);
		endcase
	endfunction

	function automatic longint harmonic_slope(longint a, longint b);
		longint ma, mb, q;
		if (a == 0 || b == 0 || ((a < 0) != (b < 0)))
			return 0;
		ma = a < 0 ? -a : a;
		mb = b < 0 ? -b : b;
		q = (((2 * ma * mb) << 16) + (ma + mb) / 2) / (ma + mb);
		return a < 0 ? -q : q;
	endfunction

	function automatic logic [VALUE_W-1:0] interp_value(query_t q);
		longint turn, ang, r, p, left, u, t, t2, t3;
		longint h00, h10, h01, h11, yp, y0, y1, yn, s0, s1, acc, den, res;
		turn = 360 * 256;
		if (q.sel == SEL_UNUSED)
			return '0;
		ang = longint'($signed(q.ang));
		r = ang % turn;
		if (r < 0)
			r += turn;
		p = r * KNOTS;
		left = (p / turn) % KNOTS;
		u = p % turn;
		t = (u << 20) / turn;
		t2 = (t * t) >>> 20;
		t3 = (t2 * t) >>> 20;
		h00 = 2 * t3 - 3 * t2 + (64'sd1 << 20);
		h10 = t3 - 2 * t2 + t;
		h01 = -2 * t3 + 3 * t2;
		h11 = t3 - t2;
		yp = knot_at(q.sel, left + KNOTS - 1);
		y0 = knot_at(q.sel, left);
		y1 = knot_at(q.sel, left + 1);
		yn = knot_at(q.sel, left + 2);
		s0 = harmonic_slope(y0 - yp, y1 - y0);
		s1 = harmonic_slope(y1 - y0, yn - y1);
		acc = (h00 * y0 + h01 * y1) * 65536 + h10 * s0 + h11 * s1;
		if (acc <= 0)
			return '0;
		den = 200 << 12;
		res = (acc + den / 2) / den;
		return res > 64'hFFFFFFFF ? 32'hFFFFFFFF : res[31:0];
	endfunction

	// input driver and output ready throttle
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_fire) begin
				send_wait = $urandom_range(0, 7);
				if ($urandom_range(0, 3) == 0)
					send_wait = 0;
			end
			if (!in_valid || in_fire) begin
				if (send_wait > 0 || pending_q.size() == 0) begin
					if (send_wait > 0)
						send_wait--;
					in_valid <= 1'b0;
				end else begin
					angle <= pending_q[0].ang;
					table_select <= pending_q[0].sel;
					pending_q.pop_front();
					in_valid <= 1'b1;
				end
			end
			if (out_fire)
				recv_wait = $urandom_range(0, 7);
			if (recv_wait > 0) begin
				recv_wait--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// monitor and scoreboard
	always @(posedge clk) begin
		in_fire = in_valid && in_ready;
		out_fire = out_valid && out_ready;
		if (arst_n) begin
			idle_cycles <= (in_fire || out_fire) ? 0 : idle_cycles + 1;
			if (in_fire) begin
				expected_values.insert(expected_values.size(),
					interp_value(query_t'{ang: angle, sel: table_select}));
				sent <= sent + 1;
			end
			if (out_fire) begin
				received <= received + 1;
				if (expected_values.size() == 0) begin
					$error("value: unexpected transfer, actual %0d", value);
					errors <= errors + 1;
				end else begin
					if (value !== expected_values[0]) begin
						$error("value: expected %0d actual %0d", expected_values[0], value);
						errors <= errors + 1;
					end
					expected_values.pop_front();
				end
			end
		end
	end

	always @(posedge clk) begin
		if (idle_cycles >= STALL_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	task automatic add_query(logic [ANGLE_W-1:0] a, logic [SEL_W-1:0] s);
		pending_q.insert(pending_q.size(), query_t'{ang: a, sel: s});
		sel_count[s]++;
	endtask

	initial begin
		int seg;
		logic [SEL_W-1:0] s;
		for (int k = 0; k < 3; k++) begin
			add_query(24'd0, SEL_SCALE + k[1:0]);
			add_query(24'h7FFFFF, SEL_SCALE + k[1:0]);
			add_query(24'h800000, SEL_SCALE + k[1:0]);
			add_query(24'hFFFFFF, SEL_SCALE + k[1:0]);
			add_query(24'd92159, SEL_SCALE + k[1:0]);
			add_query(-24'sd92160, SEL_SCALE + k[1:0]);
			add_query(24'd2880, SEL_SCALE + k[1:0]);
		end
		add_query(24'd1000, SEL_UNUSED);
		add_query(24'h800000, SEL_UNUSED);
		for (int i = 0; i < N_RANDOM; i++) begin
			s = $urandom_range(0, 9) == 0 ? SEL_UNUSED : SEL_SCALE + 2'($urandom_range(0, 2));
			case ($urandom_range(0, 3))
				0: add_query(24'($urandom), s);
				1: add_query(24'($urandom_range(0, 92159)), s);
				2: begin
					seg = (int'($urandom_range(0, 80)) - 40) * 5760
						+ int'($urandom_range(0, 2)) - 1;
					add_query(24'(seg), s);
				end
				default: add_query(24'(-$urandom_range(0, 92160 * 3)), s);
			endcase
		end
		repeat (3) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		wait (pending_q.size() == 0 && !in_valid);
		wait (expected_values.size() == 0);
		repeat (40) @(posedge clk);
		$display("Covered %0d transfers in, %0d out; tables 0/1/2/unused: %0d/%0d/%0d/%0d",
			sent, received, sel_count[0], sel_count[1], sel_count[2], sel_count[3]);
		if (errors == 0 && expected_values.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
